// ===== hdl/mfd_pkg.sv =====
`default_nettype none

package mfd_pkg;

    // default fixed point formats
    localparam int SPEED_FRAC_BITS_DEF = 16;
    localparam int STEP_FRAC_BITS_DEF  = 24;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_INERTIA_GAIN    = 2'd0,
        CFG_VISCOUS_GAIN    = 2'd1,
        CFG_STATIC_GAIN     = 2'd2,
        CFG_STATIC_DEADBAND = 2'd3
    } cfg_reg_e;

    // input transaction payload
    typedef struct packed {
        logic signed [31:0] target_speed;
        logic        [31:0] time_step;
        logic               clear_history;
    } in_item_t;

    // result transaction payload
    typedef struct packed {
        logic signed [31:0] drive_value;
        logic               clamped;
        logic               accel_skipped;
    } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/motor_feedforward_drive.sv =====
`default_nettype none

// Velocity feedforward drive: for each input transaction the block forms the
// acceleration (speed change times 2^StepFracBits over the time step, zero when
// the step is 1 us or less) and returns inertia_gain*accel + viscous_gain*speed
// plus the signed static term outside the deadband, saturated to 32 bits.
// A transaction passes a prep state, the bit-serial restoring divider, which
// produces one quotient bit per cycle over 33 + StepFracBits dividend bits
// (default Q8.24 step), and a quotient clip state, both skipped when the
// acceleration is skipped, then two passes through one shared 32x32 multiplier,
// a sum and a final saturation. item_ready is high only while the block
// is idle; the result stays on the port until it is taken. Configuration writes
// are always accepted and must be made while no transaction is in flight.
module motor_feedforward_drive #(
    parameter int SpeedFracBits = mfd_pkg::SPEED_FRAC_BITS_DEF,
    parameter int StepFracBits  = mfd_pkg::STEP_FRAC_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output      logic              item_ready,
    input  wire mfd_pkg::in_item_t item,
    output      logic              result_valid,
    input  wire logic              result_ready,
    output      mfd_pkg::out_item_t result,
    input  wire logic              cfg_valid,
    output      logic              cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [31:0]       cfg_data
);

    localparam int DW    = 33 + StepFracBits;
    localparam int CNT_W = $clog2(DW);
    localparam logic [31:0] STEP_MIN =
        32'((64'd1 << StepFracBits) / 64'd1000000);
    localparam logic [30:0] DEADBAND_RESET =
        31'((64'd1 << SpeedFracBits) / 64'd100);
    localparam logic signed [63:0] POS_LIMIT = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] NEG_LIMIT = -64'sh0000_0000_8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_SAT,
        ST_MUL_A,
        ST_MUL_V,
        ST_SUM,
        ST_FIN,
        ST_DONE
    } state_t;

    state_t state_reg;

    // configuration registers
    logic signed [31:0] inertia_gain_reg;
    logic signed [31:0] viscous_gain_reg;
    logic signed [31:0] static_gain_reg;
    logic        [30:0] static_deadband_reg;

    // history and working registers
    logic signed [31:0] last_speed_reg;
    logic signed [31:0] speed_reg;
    logic signed [31:0] prev_reg;
    logic        [31:0] step_reg;
    logic               neg_reg;
    logic               skipped_reg;
    logic               clamped_reg;
    logic   [DW-1:0]    dvd_reg;
    logic   [31:0]      rem_reg;
    logic   [32:0]      quo_reg;
    logic               ovf_reg;
    logic   [CNT_W-1:0] cnt_reg;
    logic signed [31:0] accel_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    mfd_pkg::out_item_t out_reg;

    // speed difference and magnitude
    logic signed [32:0] diff;
    logic        [32:0] mag;

    // one restoring divider step
    logic [32:0] trial;
    logic [33:0] trial_sub;
    logic        trial_ge;
    logic [31:0] rem_next;

    // quotient saturation checks
    logic big_pos;
    logic big_neg;

    // shared multiplier
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod;

    // static friction term
    logic signed [32:0] speed_ext;
    logic signed [32:0] db_ext;
    logic signed [63:0] static_term;

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = (state_reg == ST_DONE);
    assign result       = out_reg;
    assign cfg_ready    = 1'b1;

    always_comb
    begin
        diff = {speed_reg[31], speed_reg} - {prev_reg[31], prev_reg};
        mag  = diff[32] ? 33'(-diff) : 33'(diff);
    end

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DW-1]};
        trial_sub = {1'b0, trial} - {2'b00, step_reg};
        trial_ge  = !trial_sub[33];
        rem_next  = trial_ge ? trial_sub[31:0] : trial[31:0];
    end

    assign big_pos = ovf_reg | quo_reg[32] | quo_reg[31];
    assign big_neg = ovf_reg | quo_reg[32] | (quo_reg[31] & (|quo_reg[30:0]));

    always_comb
    begin
        if (state_reg == ST_MUL_A)
        begin
            mul_a = inertia_gain_reg;
            mul_b = accel_reg;
        end
        else
        begin
            mul_a = viscous_gain_reg;
            mul_b = speed_reg;
        end
        prod = mul_a * mul_b;
    end

    always_comb
    begin
        speed_ext = {speed_reg[31], speed_reg};
        db_ext    = {2'b00, static_deadband_reg};
        if (speed_ext > db_ext)
        begin
            static_term = 64'(static_gain_reg);
        end
        else if (speed_ext < -db_ext)
        begin
            static_term = -64'(static_gain_reg);
        end
        else
        begin
            static_term = '0;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inertia_gain_reg    <= '0;
            viscous_gain_reg    <= '0;
            static_gain_reg     <= '0;
            static_deadband_reg <= DEADBAND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (mfd_pkg::cfg_reg_e'(cfg_index))
                mfd_pkg::CFG_INERTIA_GAIN:    inertia_gain_reg    <= cfg_data;
                mfd_pkg::CFG_VISCOUS_GAIN:    viscous_gain_reg    <= cfg_data;
                mfd_pkg::CFG_STATIC_GAIN:     static_gain_reg     <= cfg_data;
                mfd_pkg::CFG_STATIC_DEADBAND: static_deadband_reg <= cfg_data[30:0];
                default:                      ;
            endcase
        end
    end

    // control state and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_speed_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        last_speed_reg <= item.target_speed;
                        state_reg      <= ST_PREP;
                    end
                end
                ST_PREP:  state_reg <= skipped_reg ? ST_MUL_A : ST_DIV;
                ST_DIV:   state_reg <= (cnt_reg == '0) ? ST_SAT : ST_DIV;
                ST_SAT:   state_reg <= ST_MUL_A;
                ST_MUL_A: state_reg <= ST_MUL_V;
                ST_MUL_V: state_reg <= ST_SUM;
                ST_SUM:   state_reg <= ST_FIN;
                ST_FIN:   state_reg <= ST_DONE;
                ST_DONE:
                begin
                    if (result_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                speed_reg   <= item.target_speed;
                step_reg    <= item.time_step;
                prev_reg    <= item.clear_history ? '0 : last_speed_reg;
                skipped_reg <= (item.time_step <= STEP_MIN);
                clamped_reg <= 1'b0;
            end
            ST_PREP:
            begin
                neg_reg   <= diff[32];
                dvd_reg   <= {mag, {StepFracBits{1'b0}}};
                rem_reg   <= '0;
                quo_reg   <= '0;
                ovf_reg   <= 1'b0;
                cnt_reg   <= CNT_W'(DW - 1);
                accel_reg <= '0;
            end
            ST_DIV:
            begin
                dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[31:0], trial_ge};
                ovf_reg <= ovf_reg | quo_reg[32];
                cnt_reg <= cnt_reg - 1'b1;
            end
            ST_SAT:
            begin
                // clip the quotient to the signed 32-bit range
                if (neg_reg)
                begin
                    if (big_neg)
                    begin
                        accel_reg   <= 32'sh8000_0000;
                        clamped_reg <= 1'b1;
                    end
                    else
                    begin
                        accel_reg <= -quo_reg[31:0];
                    end
                end
                else
                begin
                    if (big_pos)
                    begin
                        accel_reg   <= 32'sh7FFF_FFFF;
                        clamped_reg <= 1'b1;
                    end
                    else
                    begin
                        accel_reg <= quo_reg[31:0];
                    end
                end
            end
            ST_MUL_A:
            begin
                prod_reg <= prod;
            end
            ST_MUL_V:
            begin
                acc_reg  <= (prod_reg >>> SpeedFracBits) + static_term;
                prod_reg <= prod;
            end
            ST_SUM:
            begin
                acc_reg <= acc_reg + (prod_reg >>> SpeedFracBits);
            end
            ST_FIN:
            begin
                // saturate the drive sum
                out_reg.accel_skipped <= skipped_reg;
                if (acc_reg > POS_LIMIT)
                begin
                    out_reg.drive_value <= 32'sh7FFF_FFFF;
                    out_reg.clamped     <= 1'b1;
                end
                else if (acc_reg < NEG_LIMIT)
                begin
                    out_reg.drive_value <= 32'sh8000_0000;
                    out_reg.clamped     <= 1'b1;
                end
                else
                begin
                    out_reg.drive_value <= acc_reg[31:0];
                    out_reg.clamped     <= clamped_reg;
                end
            end
            ST_DONE:  ;
            default:  ;
        endcase
    end

endmodule

`default_nettype wire
